// ===== design/rht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and constants of the reference-counted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int HANDLE_W = 8;
    localparam int TAG_W    = 32;
    localparam int MODE_W   = 3;

    // Command queue between the front and back parts.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADDREF  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELALL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd4;

    localparam logic [HANDLE_W-1:0] ERR_HANDLE = 8'hFF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_ADDREF,
        OP_RELALL,
        OP_LOOKUP,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    object_tag;
    } t_in_item;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle_out;
        logic [TAG_W-1:0]    object_out;
        logic                is_open;
    } t_out_item;

    // Classified command as it travels from the front to the back part.
    typedef struct packed {
        t_op                 op;
        logic                in_range;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
    } t_cmd;

endpackage

// ===== design/refcounted_handle_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_handle_table
// Reference-counted handle allocator with open, close, add-reference,
// release-all and lookup operations.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter as a queue: a transfer happens at a clock edge with push
// high and full low. Each request yields exactly one result, in order. The
// oldest result sits on o_result while empty is low and is taken by a
// transfer at an edge with pop high.
// The back part handles each request in an idle state, which takes it,
// reads the tag memory at its handle and refreshes the registered
// lowest-free search, and then an execute state, which updates the
// bitmap and counts; it takes no new request until that read-then-update
// loop is through with the last one. A two-entry command queue lets
// requests keep arriving while the back part works, and the result
// register lets the back part start the next request in the same cycle
// the pending result is popped.
// If the receiver stalls, the result waits on o_result, the back part holds
// off the next request, and full rises once two requests wait in the queue.
// Synchronous reset clears the bitmap and all counts at once; the tag memory
// is not cleared, since a tag is read only while its slot is open.
// ----------------------------------------------------------------------------
module refcounted_handle_table #(
    parameter int SLOTS      = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rht_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output rht_pkg::t_out_item o_result
);
    import rht_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;
    logic w_out_valid;

    // Front part: classification and command queue.
    rht_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // Back part: slot state, tag memory and the result register.
    rht_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_out_valid (w_out_valid),
        .o_out       (o_result),
        .i_out_pop   (pop)
    );

    assign empty = !w_out_valid;

endmodule

// ===== design/rht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/rht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_front
// Accepts input transfers, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module rht_front #(
    parameter int SLOTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  rht_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output rht_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import rht_pkg::*;

    t_cmd              r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cmd              w_cmd;
    logic              w_accept;
    logic              w_take;

    // Classification of the incoming item.
    always_comb begin
        w_cmd.handle   = i_item.handle;
        w_cmd.tag      = i_item.object_tag;
        w_cmd.in_range = ({1'b0, i_item.handle} < 9'(SLOTS));
        unique case (i_item.mode)
            MODE_OPEN:   w_cmd.op = OP_OPEN;
            MODE_CLOSE:  w_cmd.op = OP_CLOSE;
            MODE_ADDREF: w_cmd.op = OP_ADDREF;
            MODE_RELALL: w_cmd.op = OP_RELALL;
            MODE_LOOKUP: w_cmd.op = OP_LOOKUP;
            default:     w_cmd.op = OP_BAD;
        endcase
    end

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign w_accept    = i_push && !o_full;
    assign o_cmd_valid = (r_count != '0);
    assign w_take      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_queue[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_accept) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_take) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_accept && !w_take) begin
            n_count = r_count + 1'b1;
        end else if (w_take && !w_accept) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_queue[r_wptr] <= w_cmd;
        end
    end

endmodule

// ===== design/rht_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_back
// Executes commands against the slot bitmap, counts and tag memory.
// ----------------------------------------------------------------------------
module rht_back #(
    parameter int SLOTS      = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  rht_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               o_out_valid,
    output rht_pkg::t_out_item o_out,
    input  logic               i_out_pop
);
    import rht_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_EXEC = 2'b10
    } t_bstate;

    t_bstate               r_state, n_state;
    t_cmd                  r_cmd;
    logic [SLOTS-1:0]      r_used, n_used;
    logic [COUNT_BITS-1:0] r_cnt [SLOTS];
    logic [COUNT_BITS-1:0] n_cnt [SLOTS];
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_free_found, n_free_found;
    logic                  r_out_valid;
    t_out_item             r_out, n_out;
    logic [TAG_W-1:0]      w_rd_tag;
    logic [IDX_W-1:0]      w_sel;
    logic [IDX_W-1:0]      w_rd_addr;
    logic                  w_open_h;
    logic                  w_tag_we;

    // Lowest free slot, registered; the bitmap is stable in the idle cycle
    // that precedes every execute cycle.
    always_comb begin
        n_free_found = 1'b0;
        n_free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                n_free_found = 1'b1;
                n_free_idx   = IDX_W'(i);
            end
        end
    end

    assign o_cmd_take  = (r_state == BS_IDLE) && i_cmd_valid &&
                         (!r_out_valid || i_out_pop);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_rd_addr   = i_cmd.handle[IDX_W-1:0];
    assign w_sel       = r_cmd.handle[IDX_W-1:0];
    assign w_open_h    = r_cmd.in_range && r_used[w_sel];
    assign w_tag_we    = (r_state == BS_EXEC) && (r_cmd.op == OP_OPEN) && r_free_found;

    rht_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (r_free_idx),
        .i_wdata (r_cmd.tag),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_tag)
    );

    always_comb begin
        n_used = r_used;
        n_cnt  = r_cnt;
        n_out.status     = STATUS_ERR;
        n_out.handle_out = r_cmd.handle;
        n_out.object_out = '0;
        n_out.is_open    = 1'b0;
        unique case (r_cmd.op)
            OP_OPEN: begin
                if (r_free_found) begin
                    n_used[r_free_idx] = 1'b1;
                    n_cnt[r_free_idx]  = COUNT_BITS'(1);
                    n_out.status       = STATUS_OK;
                    n_out.handle_out   = HANDLE_W'(r_free_idx);
                end else begin
                    n_out.handle_out   = ERR_HANDLE;
                end
            end
            OP_CLOSE: begin
                if (w_open_h) begin
                    if (r_cnt[w_sel] != '0) begin
                        n_cnt[w_sel] = r_cnt[w_sel] - 1'b1;
                    end
                    if (n_cnt[w_sel] == '0) begin
                        n_used[w_sel] = 1'b0;
                    end
                    n_out.status = STATUS_OK;
                end
            end
            OP_ADDREF: begin
                if (w_open_h) begin
                    if (r_cnt[w_sel] != '1) begin
                        n_cnt[w_sel] = r_cnt[w_sel] + 1'b1;
                    end
                    n_out.status = STATUS_OK;
                end
            end
            OP_RELALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r_used[i]) begin
                        if (r_cnt[i] != '0) begin
                            n_cnt[i] = r_cnt[i] - 1'b1;
                        end
                        if (n_cnt[i] == '0) begin
                            n_used[i] = 1'b0;
                        end
                    end
                end
                n_out.status = STATUS_OK;
            end
            OP_LOOKUP: begin
                if (w_open_h) begin
                    n_out.object_out = w_rd_tag;
                    n_out.status     = STATUS_OK;
                end
            end
            default: begin
            end
        endcase
        // Open reports its own success; every other operation reports the
        // addressed slot's flag after the update.
        if (r_cmd.op == OP_OPEN) begin
            n_out.is_open = (n_out.status == STATUS_OK);
        end else begin
            n_out.is_open = r_cmd.in_range && n_used[w_sel];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (o_cmd_take) n_state = BS_EXEC;
            BS_EXEC: n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            if (r_state == BS_EXEC) begin
                r_used      <= n_used;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == BS_EXEC) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/rht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_checker
// Port-level checks of the handle table, attached by bind.
// ----------------------------------------------------------------------------
module rht_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input rht_pkg::t_in_item  i_item,
    input logic               empty,
    input logic               pop,
    input rht_pkg::t_out_item o_result
);
    import rht_pkg::*;

    // Reset leaves no result waiting and room for requests.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue state not cleared by reset");

    // A waiting result holds until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed before its transfer");

    // Failed operations never expose a tag.
    a_err_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == STATUS_ERR |-> o_result.object_out == '0)
        else $error("error result carries a tag");

    // A tag is only returned for an open slot on success.
    a_tag_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.object_out != '0 |->
            o_result.status == STATUS_OK && o_result.is_open)
        else $error("tag returned for a closed slot");

    // An offered request carries a fully known payload.
    a_push_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !$isunknown(i_item))
        else $error("request offered with unknown payload");

endmodule

bind refcounted_handle_table rht_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
